// ===== rtl/cdq_pkg.sv =====
package cdq_pkg;

    // default build
    localparam int DEF_SLOT_COUNT = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int PUSH_VAL_W = 32;
    localparam int POP_VAL_W  = 32;
    localparam int STAT_W     = 2;
    localparam int CNT_W      = 4;
    localparam int QSIZE_W    = 5;
    localparam logic [QSIZE_W-1:0] QSIZE_RESET = 5'd16;

    // m_tdata: pop_value, status, element_count, is_empty, is_full, padded to bytes
    localparam int M_FIELDS_W = POP_VAL_W + STAT_W + CNT_W + 2;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE,
        STAT_OVERFLOW,
        STAT_UNDERFLOW
    } stat_t;

    typedef enum logic {
        CS_IDLE,
        CS_READ
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // take the item on the slave side this cycle
        logic load_pop;  // registered slot read is ready, complete the pop
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pop_ok;    // item at the slave side is a pop on a non-empty queue
        logic out_free;  // output register empty or being taken
    } dp_stat_t;

endpackage

// ===== rtl/cdq_ctrl.sv =====
module cdq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cdq_pkg::dp_stat_t  stat,
    output cdq_pkg::ctrl_cmd_t cmd
);
    import cdq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.load_pop = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                s_tready   = stat.out_free;
                cmd.accept = stat.out_free && s_tvalid;
                if (cmd.accept && stat.pop_ok) begin
                    state_next = CS_READ;
                end
            end
            CS_READ: begin
                // slot data arrives from the registered read
                cmd.load_pop = 1'b1;
                state_next   = CS_IDLE;
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/cdq_dpath.sv =====
module cdq_dpath #(
    parameter int SLOT_COUNT = cdq_pkg::DEF_SLOT_COUNT,
    parameter int DATA_WIDTH = cdq_pkg::DEF_DATA_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [cdq_pkg::OP_W-1:0]       s_tuser,
    input  logic [cdq_pkg::PUSH_VAL_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cdq_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cdq_pkg::QSIZE_W-1:0]    cfg_data,
    input  cdq_pkg::ctrl_cmd_t             cmd,
    output cdq_pkg::dp_stat_t              stat
);
    import cdq_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int NW = $clog2(SLOT_COUNT + 1);
    localparam int QW = (NW > QSIZE_W) ? NW : QSIZE_W;

    logic [DATA_WIDTH-1:0] mem [SLOT_COUNT];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [QSIZE_W-1:0] qsize_reg;
    logic [IW-1:0]      front_reg, front_next;
    logic [IW-1:0]      back_reg, back_next;

    logic                 out_valid_reg, out_valid_next;
    logic [POP_VAL_W-1:0] out_pop_reg;
    stat_t                out_stat_reg;
    logic [CNT_W-1:0]     out_cnt_reg;
    logic                 out_empty_reg;
    logic                 out_full_reg;

    logic [QW-1:0] qs_w;
    logic [NW-1:0] n_slots;
    op_t           op;
    logic          q_full, q_empty;
    logic          fault;
    stat_t         res_stat;
    logic          wr_en;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [NW:0]   diff;
    logic [CNT_W-1:0] res_cnt;
    logic          res_empty, res_full;

    function automatic logic [IW-1:0] step_up(input logic [IW-1:0] i, input logic [NW-1:0] n);
        if (NW'(i) == n - NW'(1)) begin
            return '0;
        end
        return i + IW'(1);
    endfunction

    function automatic logic [IW-1:0] step_down(input logic [IW-1:0] i,
                                                input logic [NW-1:0] n);
        if (i == '0) begin
            return IW'(n - NW'(1));
        end
        return i - IW'(1);
    endfunction

    // slots in use, clamped to 2..SLOT_COUNT
    always_comb begin
        qs_w = QW'(qsize_reg);
        if (qs_w < QW'(2)) begin
            n_slots = NW'(2);
        end else if (qs_w > QW'(SLOT_COUNT)) begin
            n_slots = NW'(SLOT_COUNT);
        end else begin
            n_slots = NW'(qs_w);
        end
    end

    assign op      = op_t'(s_tuser);
    assign q_full  = (step_up(back_reg, n_slots) == front_reg);
    assign q_empty = (back_reg == front_reg);
    assign wr_data = DATA_WIDTH'(s_tdata);

    always_comb begin
        front_next = front_reg;
        back_next  = back_reg;
        wr_en      = 1'b0;
        wr_addr    = front_reg;
        rd_addr    = back_reg;
        fault      = 1'b0;
        res_stat   = STAT_DONE;
        unique case (op)
            OP_PUSH_FRONT: begin
                fault   = q_full;
                wr_addr = front_reg;
                if (!q_full) begin
                    wr_en      = cmd.accept;
                    front_next = step_down(front_reg, n_slots);
                end
            end
            OP_PUSH_BACK: begin
                fault   = q_full;
                wr_addr = step_up(back_reg, n_slots);
                if (!q_full) begin
                    wr_en     = cmd.accept;
                    back_next = wr_addr;
                end
            end
            OP_POP_FRONT: begin
                fault   = q_empty;
                rd_addr = step_up(front_reg, n_slots);
                if (!q_empty) begin
                    front_next = rd_addr;
                end
            end
            OP_POP_BACK: begin
                fault   = q_empty;
                rd_addr = back_reg;
                if (!q_empty) begin
                    back_next = step_down(back_reg, n_slots);
                end
            end
            default: begin
                fault = 1'b0;
            end
        endcase
        if (fault) begin
            res_stat = (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) ? STAT_OVERFLOW
                                                                   : STAT_UNDERFLOW;
        end
    end

    // occupancy after the operation
    always_comb begin
        diff = (NW+1)'(back_next) + (NW+1)'(n_slots) - (NW+1)'(front_next);
        if (diff >= (NW+1)'(n_slots)) begin
            diff = diff - (NW+1)'(n_slots);
        end
        res_cnt   = CNT_W'(diff);
        res_empty = (back_next == front_next);
        res_full  = (step_up(back_next, n_slots) == front_next);
    end

    assign stat.pop_ok   = (op == OP_POP_FRONT || op == OP_POP_BACK) && !q_empty;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign cfg_ready     = 1'b1;

    // slot store, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qsize_reg <= QSIZE_RESET;
            front_reg <= '0;
            back_reg  <= '0;
        end else if (cfg_valid) begin
            qsize_reg <= cfg_data;
            front_reg <= '0;
            back_reg  <= '0;
        end else if (cmd.accept) begin
            front_reg <= front_next;
            back_reg  <= back_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if ((cmd.accept && !stat.pop_ok) || cmd.load_pop) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            out_pop_reg   <= '0;
            out_stat_reg  <= res_stat;
            out_cnt_reg   <= res_cnt;
            out_empty_reg <= res_empty;
            out_full_reg  <= res_full;
        end else if (cmd.load_pop) begin
            out_pop_reg <= POP_VAL_W'(rd_data_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_full_reg, out_empty_reg, out_cnt_reg,
                                 out_stat_reg, out_pop_reg});

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (NW'(front_reg) < n_slots) && (NW'(back_reg) < n_slots))
        else $error("deque index outside slots in use");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> (!out_valid_reg || m_tready))
        else $error("item accepted while result register blocked");

    a_pop_completes: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && stat.pop_ok) |=> (cmd.load_pop && !out_valid_reg))
        else $error("pop did not complete in the following cycle");

    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_stat_reg != STAT_DONE) |-> (out_pop_reg == '0))
        else $error("faulted operation returned a value");

endmodule

// ===== rtl/circular_deque.sv =====
// A push or a faulted operation shows its result item in the cycle after acceptance;
//   a successful pop shows it after the registered slot store read, loaded in CS_READ.
// Throughput: pushes and faults 1 item per cycle, pops stall input during the slot read.
//   A waiting result does not block the next item while m_tready is high.
// Reset (aresetn low, synchronous): queue emptied, queue_size back to 16, output valid cleared;
//   slot store contents are not cleared. A queue_size write also empties the queue.
module circular_deque #(
    parameter int SLOT_COUNT = cdq_pkg::DEF_SLOT_COUNT,
    parameter int DATA_WIDTH = cdq_pkg::DEF_DATA_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cdq_pkg::PUSH_VAL_W-1:0] s_tdata,   // [31:0] push_value
    input  logic [cdq_pkg::OP_W-1:0]       s_tuser,   // [1:0] operation
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] pop_value, [33:32] status, [37:34] element_count,
    // [38] is_empty, [39] is_full
    output logic [cdq_pkg::M_DATA_W-1:0]   m_tdata,
    // queue_size register write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cdq_pkg::QSIZE_W-1:0]    cfg_data
);
    import cdq_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Controller: accepts an item when the result register is free, and
    // holds a pop in the CS_READ state while the slot read completes.
    cdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: front/back indices with wrap, slot store, result register.
    cdq_dpath #(
        .SLOT_COUNT (SLOT_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
